// ===== hw/rtl/pclt_pkg.sv =====
// shared types and constants for the piecewise linear curve table
package pclt_pkg;

  localparam int DW = 32;
  localparam int PROD_W = 66;
  localparam int DIVR_W = 33;

  typedef enum logic [2:0] {
    REQ_INSERT      = 3'd0,
    REQ_EVAL        = 3'd1,
    REQ_CLEAR_AFTER = 3'd2,
    REQ_NZ_VALUE    = 3'd3,
    REQ_NZ_SLOPE    = 3'd4,
    REQ_CLEAR_ALL   = 3'd5,
    REQ_TAIL        = 3'd6,
    REQ_HEAD        = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CMP,
    S_POST,
    S_SRCH,
    S_SRCH_CMP,
    S_HT,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_SUM
  } state_t;

endpackage

// ===== hw/rtl/pclt_mem.sv =====
// key store: param and value arrays, one write and one registered read per cycle
module pclt_mem #(
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [pclt_pkg::DW-1:0] wparam,
  input  logic [pclt_pkg::DW-1:0] wvalue,
  input  logic [AW-1:0]        raddr,
  output logic [pclt_pkg::DW-1:0] rparam,
  output logic [pclt_pkg::DW-1:0] rvalue
);

  logic [pclt_pkg::DW-1:0] param_mem [2**AW];
  logic [pclt_pkg::DW-1:0] value_mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      param_mem[waddr] <= wparam;
      value_mem[waddr] <= wvalue;
    end
    rparam <= param_mem[raddr];
    rvalue <= value_mem[raddr];
  end

endmodule

// ===== hw/rtl/pclt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module pclt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pclt_pkg::PROD_W-1:0]   dividend,
  input  logic [pclt_pkg::DIVR_W-1:0]   divisor,
  output logic                          done,
  output logic [pclt_pkg::PROD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(pclt_pkg::PROD_W + 1);

  logic [pclt_pkg::DIVR_W:0]   rem;
  logic [pclt_pkg::DIVR_W-1:0] dvsr;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic [pclt_pkg::DIVR_W:0]   trial;

  assign trial = {rem[pclt_pkg::DIVR_W-1:0], quotient[pclt_pkg::PROD_W-1]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
      cnt      <= CNT_W'(pclt_pkg::PROD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (!trial[pclt_pkg::DIVR_W]) begin
        rem      <= trial;
        quotient <= {quotient[pclt_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem      <= {rem[pclt_pkg::DIVR_W-1:0], quotient[pclt_pkg::PROD_W-1]};
        quotient <= {quotient[pclt_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/piecewise_linear_curve_table_top.sv =====
// Sorted key table with linear interpolation. One transaction at a time: a request
// walks from the tail down to the floor key, a read and a compare per key (insert
// shifts keys up in the same walk), the searches walk upward from there in the same
// way, evaluate adds a multiply state, a start state, a 66-step serial division and a
// final add state, and head or tail read one key directly. The registered read of the
// key store is why each key walked takes a read state and a compare state.
module piecewise_linear_curve_table_top #(
  parameter int MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic signed [31:0] key_param,
  input  logic signed [31:0] key_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic signed [31:0] out_param,
  output logic signed [31:0] out_value,
  output logic [6:0]  held_count
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int DW = pclt_pkg::DW;

  pclt_pkg::state_t state, state_next;
  pclt_pkg::req_t   req;
  logic [CW-1:0]    n, idx, fl, start_k;
  logic signed [DW-1:0] t, val;
  logic signed [DW-1:0] cur_p, cur_v, nxt_p, nxt_v;
  logic [pclt_pkg::PROD_W-1:0] prod;
  logic             dv_neg;
  logic [pclt_pkg::DIVR_W-1:0] dp;

  logic             accept;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DW-1:0]    wparam, wvalue;
  logic signed [DW-1:0] rd_p, rd_v;
  logic             div_start;
  logic             div_done;
  logic [pclt_pkg::PROD_W-1:0] quot;

  logic signed [DW:0] dv_w, d_w;
  logic [DW:0]        mag_w;
  logic signed [DW+2:0] sum_w;
  logic               hit_val, hit_slope, hit_prev, iv_nz;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != pclt_pkg::S_IDLE) || out_valid;

  pclt_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wparam(wparam), .wvalue(wvalue),
    .raddr(raddr), .rparam(rd_p), .rvalue(rd_v)
  );

  pclt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod), .divisor(dp),
    .done(div_done), .quotient(quot)
  );

  assign dv_w  = {nxt_v[DW-1], nxt_v} - {cur_v[DW-1], cur_v};
  assign d_w   = {t[DW-1], t} - {cur_p[DW-1], cur_p};
  assign mag_w = dv_w[DW] ? (DW+1)'(-dv_w) : dv_w;
  assign sum_w = dv_neg ? ((DW+3)'(cur_v) - (DW+3)'({1'b0, quot[DW+1:0]}))
                        : ((DW+3)'(cur_v) + (DW+3)'({1'b0, quot[DW+1:0]}));

  // search hit logic: cur is the previous entry, rd is the entry at idx
  assign iv_nz     = (cur_p == rd_p) || (cur_v != rd_v);
  assign hit_val   = (idx >= fl) && (rd_v != '0);
  assign hit_prev  = (idx > start_k) && iv_nz && (idx - CW'(1) >= fl);
  assign hit_slope = (n == CW'(1)) ? (idx >= fl)
                   : (idx > start_k) && iv_nz && (hit_prev || (idx == n - CW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pclt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wparam     = rd_p;
    wvalue     = rd_v;
    raddr      = '0;
    div_start  = 1'b0;
    unique case (state)
      pclt_pkg::S_IDLE: begin
        if (accept) begin
          if (n == '0 && req_type != pclt_pkg::REQ_INSERT
              && req_type != pclt_pkg::REQ_CLEAR_ALL) begin
            state_next = pclt_pkg::S_IDLE;
          end else if (req_type == pclt_pkg::REQ_HEAD) begin
            state_next = pclt_pkg::S_HT;
          end else if (req_type == pclt_pkg::REQ_TAIL) begin
            raddr      = AW'(n - CW'(1));
            state_next = pclt_pkg::S_HT;
          end else if (req_type == pclt_pkg::REQ_CLEAR_ALL ||
                       (req_type == pclt_pkg::REQ_INSERT && n == CW'(MAX_KEYS))) begin
            state_next = pclt_pkg::S_IDLE;
          end else begin
            state_next = pclt_pkg::S_SCAN;
          end
        end
      end
      pclt_pkg::S_SCAN: begin
        raddr = AW'(idx - CW'(1));
        state_next = (idx == '0) ? pclt_pkg::S_POST : pclt_pkg::S_SCAN_CMP;
      end
      pclt_pkg::S_SCAN_CMP: begin
        if (rd_p <= t) begin
          state_next = pclt_pkg::S_POST;
        end else begin
          we         = (req == pclt_pkg::REQ_INSERT);
          state_next = pclt_pkg::S_SCAN;
        end
      end
      pclt_pkg::S_POST: begin
        state_next = pclt_pkg::S_IDLE;
        priority case (req)
          pclt_pkg::REQ_INSERT: begin
            we     = 1'b1;
            waddr  = fl[AW-1:0];
            wparam = t;
            wvalue = val;
          end
          pclt_pkg::REQ_EVAL: begin
            if (fl != '0 && fl < n && t > cur_p) state_next = pclt_pkg::S_MUL;
          end
          pclt_pkg::REQ_NZ_VALUE, pclt_pkg::REQ_NZ_SLOPE: state_next = pclt_pkg::S_SRCH;
          default: state_next = pclt_pkg::S_IDLE;
        endcase
      end
      pclt_pkg::S_SRCH: begin
        raddr      = idx[AW-1:0];
        state_next = (idx >= n) ? pclt_pkg::S_IDLE : pclt_pkg::S_SRCH_CMP;
      end
      pclt_pkg::S_SRCH_CMP: begin
        if (((req == pclt_pkg::REQ_NZ_VALUE) ? hit_val : hit_slope)
            || idx == n - CW'(1)) begin
          state_next = pclt_pkg::S_IDLE;
        end else begin
          state_next = pclt_pkg::S_SRCH;
        end
      end
      pclt_pkg::S_HT:     state_next = pclt_pkg::S_IDLE;
      pclt_pkg::S_MUL:    state_next = pclt_pkg::S_DIV_GO;
      pclt_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = pclt_pkg::S_DIV;
      end
      pclt_pkg::S_DIV:    if (div_done) state_next = pclt_pkg::S_SUM;
      pclt_pkg::S_SUM:    state_next = pclt_pkg::S_IDLE;
      default:            state_next = pclt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      n         <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        pclt_pkg::S_IDLE: begin
          if (accept) begin
            req       <= pclt_pkg::req_t'(req_type);
            t         <= key_param;
            val       <= key_value;
            idx       <= n;
            status    <= pclt_pkg::ST_OK;
            found     <= 1'b0;
            out_param <= '0;
            out_value <= '0;
            if (n == '0 && req_type != pclt_pkg::REQ_INSERT
                && req_type != pclt_pkg::REQ_CLEAR_ALL) begin
              status    <= pclt_pkg::ST_EMPTY;
              out_valid <= 1'b1;
            end else if (req_type == pclt_pkg::REQ_CLEAR_ALL) begin
              n         <= '0;
              out_valid <= 1'b1;
            end else if (req_type == pclt_pkg::REQ_INSERT && n == CW'(MAX_KEYS)) begin
              status    <= pclt_pkg::ST_FULL;
              out_valid <= 1'b1;
            end
            held_count <= (req_type == pclt_pkg::REQ_CLEAR_ALL) ? '0 : 7'(n);
          end
        end
        pclt_pkg::S_SCAN: begin
          if (idx == '0) fl <= '0;
        end
        pclt_pkg::S_SCAN_CMP: begin
          cur_p <= rd_p;
          cur_v <= rd_v;
          nxt_p <= cur_p;
          nxt_v <= cur_v;
          if (rd_p <= t) begin
            fl <= idx;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        pclt_pkg::S_POST: begin
          priority case (req)
            pclt_pkg::REQ_INSERT: begin
              n          <= n + CW'(1);
              held_count <= 7'(n + CW'(1));
              out_valid  <= 1'b1;
            end
            pclt_pkg::REQ_EVAL: begin
              if (!(fl != '0 && fl < n && t > cur_p)) begin
                out_value <= cur_v;
                out_valid <= 1'b1;
              end
            end
            pclt_pkg::REQ_CLEAR_AFTER: begin
              n          <= fl;
              held_count <= 7'(fl);
              out_valid  <= 1'b1;
            end
            pclt_pkg::REQ_NZ_SLOPE: begin
              idx     <= (fl != '0) ? fl - CW'(1) : fl;
              start_k <= (fl != '0) ? fl - CW'(1) : fl;
            end
            default: begin
              idx     <= fl;
              start_k <= fl;
            end
          endcase
        end
        pclt_pkg::S_SRCH: begin
          if (idx >= n) out_valid <= 1'b1;
        end
        pclt_pkg::S_SRCH_CMP: begin
          cur_p <= rd_p;
          cur_v <= rd_v;
          idx   <= idx + CW'(1);
          if ((req == pclt_pkg::REQ_NZ_VALUE) ? hit_val : hit_slope) begin
            found     <= 1'b1;
            out_valid <= 1'b1;
            if (req == pclt_pkg::REQ_NZ_SLOPE && n != CW'(1) && hit_prev) begin
              out_param <= cur_p;
              out_value <= cur_v;
            end else begin
              out_param <= rd_p;
              out_value <= rd_v;
            end
          end else if (idx == n - CW'(1)) begin
            out_valid <= 1'b1;
          end
        end
        pclt_pkg::S_HT: begin
          found     <= 1'b1;
          out_param <= rd_p;
          out_value <= rd_v;
          out_valid <= 1'b1;
        end
        pclt_pkg::S_MUL: begin
          prod   <= pclt_pkg::PROD_W'(mag_w) * pclt_pkg::PROD_W'(d_w[DW:0]);
          dv_neg <= dv_w[DW];
          dp     <= pclt_pkg::DIVR_W'({nxt_p[DW-1], nxt_p} - {cur_p[DW-1], cur_p});
        end
        pclt_pkg::S_DIV_GO: ;
        pclt_pkg::S_DIV: ;
        pclt_pkg::S_SUM: begin
          if (sum_w > (DW+3)'(signed'(32'sh7fffffff))) begin
            out_value <= 32'sh7fffffff;
          end else if (sum_w < -(DW+3)'(signed'(33'sh080000000))) begin
            out_value <= 32'sh80000000;
          end else begin
            out_value <= sum_w[DW-1:0];
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_KEYS))
    else $error("key count above capacity");

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second transaction accepted while busy");

  // store writes only from the insert walk
  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    we |-> (req == pclt_pkg::REQ_INSERT))
    else $error("store written outside insert");

  // full status only for insert
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pclt_pkg::ST_FULL) |-> (req == pclt_pkg::REQ_INSERT))
    else $error("full status on non-insert");

endmodule
